// ----- src/bmpgd_pkg.sv -----
package bmpgd_pkg;

   // Key codes of a result
   localparam logic [1:0] KEY_REWIND   = 2'd0;
   localparam logic [1:0] KEY_ESCAPE   = 2'd1;
   localparam logic [1:0] KEY_POWEROFF = 2'd2;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_HOLD_SECONDS         = 2'd0;
   localparam logic [1:0] CSR_ESCAPE_PRESS_COUNT   = 2'd1;
   localparam logic [1:0] CSR_SHUTDOWN_PRESS_COUNT = 2'd2;

   // Reset values of the registers
   localparam logic [3:0] HOLD_SECONDS_RESET         = 4'd1;
   localparam logic [7:0] ESCAPE_PRESS_COUNT_RESET   = 8'd3;
   localparam logic [7:0] SHUTDOWN_PRESS_COUNT_RESET = 8'd5;

   // A lone press in a gesture, the one that drives the rewind key
   localparam logic [7:0] PRESS_SINGLE = 8'd1;
   localparam logic [3:0] SECONDS_MAX  = 4'd15;

   // Command queue between the classifier and the event sequencer
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   typedef struct packed {
      logic       button_level;
      logic [3:0] second_boundaries;
   } req_type;

   typedef struct packed {
      logic [1:0] key_code;
      logic       key_value;
      logic       shutdown_request;
      logic       last_of_run;
   } rsp_type;

   // One classified sample: a single key event, or a press/release pair
   typedef struct packed {
      logic [1:0] key_code;
      logic       pair;
      logic       key_value;
   } cmd_type;

   // Configuration as seen by the classifier
   typedef struct packed {
      logic [3:0] hold_seconds;
      logic [7:0] escape_press_count;
      logic [7:0] shutdown_press_count;
   } cfg_type;

endpackage

// ----- src/bmpgd_front.sv -----
module bmpgd_front
   import bmpgd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    push_valid,
   input  logic    push_ready,
   output cmd_type push_cmd
);

   typedef enum logic [1:0] {
      PHASE_IDLE     = 2'd0,
      PHASE_PRESSED  = 2'd1,
      PHASE_RELEASED = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] press_count_ff, press_count_in;
   logic [3:0] elapsed_ff, elapsed_in;
   logic       halted_ff, halted_in;
   logic       accept;

   // Take a sample whenever the queue has room for its command
   assign req_ready = push_ready;
   assign accept    = req_valid & push_ready;

   // Classify the sample and advance the gesture state
   always_comb begin
      logic [4:0] sum;
      logic [3:0] elapsed_sat;
      logic       timed_out;

      sum         = {1'b0, elapsed_ff} + {1'b0, req_data.second_boundaries};
      elapsed_sat = sum[4] ? SECONDS_MAX : sum[3:0];
      timed_out   = elapsed_sat > cfg.hold_seconds;

      phase_in       = phase_ff;
      press_count_in = press_count_ff;
      elapsed_in     = elapsed_ff;
      halted_in      = halted_ff;
      push_valid     = 1'b0;
      push_cmd       = '0;

      if (accept && !halted_ff) begin
         elapsed_in = elapsed_sat;
         case (phase_ff)
            PHASE_PRESSED: begin
               if (!req_data.button_level) begin
                  elapsed_in = '0;
                  phase_in   = PHASE_RELEASED;
               end else if (press_count_ff == PRESS_SINGLE && timed_out) begin
                  // repeat the rewind press while held
                  push_valid         = 1'b1;
                  push_cmd.key_code  = KEY_REWIND;
                  push_cmd.key_value = 1'b1;
               end
            end
            PHASE_RELEASED: begin
               if (!req_data.button_level && timed_out) begin
                  // gesture ends: pick the action by press count
                  if (press_count_ff == PRESS_SINGLE) begin
                     push_valid         = 1'b1;
                     push_cmd.key_code  = KEY_REWIND;
                     push_cmd.key_value = 1'b0;
                  end else if (press_count_ff == cfg.escape_press_count) begin
                     push_valid        = 1'b1;
                     push_cmd.key_code = KEY_ESCAPE;
                     push_cmd.pair     = 1'b1;
                  end else if (press_count_ff == cfg.shutdown_press_count) begin
                     push_valid        = 1'b1;
                     push_cmd.key_code = KEY_POWEROFF;
                     push_cmd.pair     = 1'b1;
                     halted_in         = 1'b1;
                  end
                  elapsed_in     = '0;
                  phase_in       = PHASE_IDLE;
                  press_count_in = '0;
               end else if (req_data.button_level) begin
                  elapsed_in     = '0;
                  phase_in       = PHASE_PRESSED;
                  press_count_in = press_count_ff + 8'd1;
               end
            end
            default: begin
               if (req_data.button_level) begin
                  elapsed_in     = '0;
                  phase_in       = PHASE_PRESSED;
                  press_count_in = press_count_ff + 8'd1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_IDLE;
         press_count_ff <= '0;
         elapsed_ff     <= '0;
         halted_ff      <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         press_count_ff <= press_count_in;
         elapsed_ff     <= elapsed_in;
         halted_ff      <= halted_in;
      end
   end

endmodule

// ----- src/bmpgd_queue.sv -----
module bmpgd_queue
   import bmpgd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  push, pop;

   assign push_ready = count_ff != QUEUE_DEPTH[QUEUE_AW:0];
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- src/bmpgd_back.sv -----
module bmpgd_back
   import bmpgd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    pop_valid,
   output logic    pop_ready,
   input  cmd_type pop_cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       second_ff, second_in;
   logic [1:0] pend_key_ff, pend_key_in;
   logic       slot_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pop_ready = slot_free && !second_ff;

   // Load the output register: release half of a pair first, else a new command
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      second_in    = second_ff;
      pend_key_in  = pend_key_ff;
      if (slot_free) begin
         rsp_valid_in = 1'b0;
         if (second_ff) begin
            rsp_valid_in                 = 1'b1;
            rsp_data_in.key_code         = pend_key_ff;
            rsp_data_in.key_value        = 1'b0;
            rsp_data_in.shutdown_request = pend_key_ff == KEY_POWEROFF;
            rsp_data_in.last_of_run      = 1'b1;
            second_in                    = 1'b0;
         end else if (pop_valid) begin
            rsp_valid_in                 = 1'b1;
            rsp_data_in.key_code         = pop_cmd.key_code;
            rsp_data_in.key_value        = pop_cmd.pair | pop_cmd.key_value;
            rsp_data_in.shutdown_request = pop_cmd.key_code == KEY_POWEROFF;
            rsp_data_in.last_of_run      = !pop_cmd.pair;
            second_in                    = pop_cmd.pair;
            pend_key_in                  = pop_cmd.key_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
      rsp_data_ff <= rsp_data_in;
      pend_key_ff <= pend_key_in;
   end

endmodule

// ----- src/button_multi_press_gesture_detector_core.sv -----
// Multi-press button gesture detector. Each accepted poll sample (button level and
// seconds passed since the previous poll) is classified combinationally and advances
// the idle/pressed/released gesture state; a sample may be taken every cycle while
// the two-entry command queue has room. Key events leave through the command queue
// and then a registered output: a rewind event is one response, an escape or
// power-off pair is a press response and then a release response. Samples with at
// most one event are taken one per cycle while the output drains; a pair holds back
// the next command until its release half has left the single output register.
// After the power-off pair the block stays dormant (samples are taken, no events)
// until reset. Configuration writes must happen only while no events are pending.
module button_multi_press_gesture_detector_core
   import bmpgd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_seconds         <= HOLD_SECONDS_RESET;
         cfg_ff.escape_press_count   <= ESCAPE_PRESS_COUNT_RESET;
         cfg_ff.shutdown_press_count <= SHUTDOWN_PRESS_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HOLD_SECONDS:         cfg_ff.hold_seconds         <= csr_wdata[3:0];
            CSR_ESCAPE_PRESS_COUNT:   cfg_ff.escape_press_count   <= csr_wdata;
            CSR_SHUTDOWN_PRESS_COUNT: cfg_ff.shutdown_press_count <= csr_wdata;
            default: ;
         endcase
      end
   end

   bmpgd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   bmpgd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   bmpgd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
